/* sv/clsu_pkg.sv */
`timescale 1ns / 1ps
// clsu_pkg: shared types, constants and the crc-16 helper for the command link supervisor
// used by every module of the block; depends on nothing

package clsu_pkg;

    localparam int unsigned Q_DEPTH  = 2;
    localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'h0000;
    localparam logic [7:0]  RX_GOOD_LEN   = 8'd4;
    localparam logic [7:0]  CMD_MASK      = 8'h7F | 8'h80;
    localparam int unsigned RX_STALL_BIT  = 8;
    localparam int unsigned RX_FULL_BIT   = 9;

    localparam logic [15:0] TIMEOUT_RESET = 16'd50;
    localparam logic [7:0]  LIMIT_RESET   = 8'd5;

    typedef enum logic [0:0] {
        REG_TIMEOUT_TICKS = 1'b0,
        REG_MISSED_LIMIT  = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_SEND   = 2'd0,
        OP_PACKET = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  cmd;
        logic [15:0] crc;
        logic        rx_ok;
        logic        stall;
        logic        full;
    } entry_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_data;
        logic [15:0] tx_checksum;
        logic        ack_seen;
        logic        desync_light;
        logic        stall_light;
        logic        full_light;
        logic [7:0]  missed_count;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        logic [7:0]  b;
        logic        fb;
        crc = crc_in;
        b   = data;
        for (int i = 0; i < 8; i++)
        begin
            fb  = crc[0] ^ b[0];
            crc = crc >> 1;
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

    function automatic logic [15:0] crc_word(input logic [15:0] word);
        return crc_byte(crc_byte(CRC_INIT, word[7:0]), word[15:8]);
    endfunction

endpackage

/* sv/command_echo_link_supervisor.sv */
`timescale 1ns / 1ps
// command_echo_link_supervisor: top level of the command link supervisor
// instantiates clsu_front, clsu_queue and clsu_back; uses clsu_pkg

// Takes one item per clock while s_tready is high and returns exactly one result item
// for each, in order. Each item is first written into the two-entry queue behind the
// classifier and is then loaded into the output register of the execution stage, from
// which it is presented as the result item.
// The execution stage retires one item per cycle while the output side takes results;
// when the output stalls the queue fills and s_tready drops once it holds two items.
// Send items return the frame with its crc-16 (poly 0xA001, init 0, low byte first);
// every result reports the missed count and the desync, stall and full lights.
// Configuration writes (index 0 timeout_ticks, index 1 missed_limit) take effect at once
// and are expected while no item is in flight.

module command_echo_link_supervisor
    import clsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // switches, rx_length, rx_data, rx_checksum
    input  logic [1:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // tx_data, tx_checksum, ack_seen, desync_light,
                                  // stall_light, full_light, missed_count, zero pad
    output logic [0:0]  m_tuser   // tx_valid
);

    entry_t  front_entry;
    entry_t  q_entry;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    in_accept;
    result_t result;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    clsu_front u_front (
        .operation   (s_tuser),
        .switches    (s_tdata[7:0]),
        .rx_length   (s_tdata[15:8]),
        .rx_data     (s_tdata[31:16]),
        .rx_checksum (s_tdata[47:32]),
        .entry       (front_entry)
    );

    clsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_accept),
        .wr_entry (front_entry),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_entry (q_entry)
    );

    clsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tuser = result.tx_valid;
    assign m_tdata = {4'h0, result.missed_count, result.full_light, result.stall_light,
                      result.desync_light, result.ack_seen, result.tx_checksum,
                      result.tx_data};

endmodule

/* sv/clsu_front.sv */
`timescale 1ns / 1ps
// clsu_front: accepts input items and classifies them into queue entries
// computes the crc of the outgoing command or checks the received packet; uses clsu_pkg

module clsu_front
    import clsu_pkg::*;
(
    input  logic [1:0]  operation,
    input  logic [7:0]  switches,
    input  logic [7:0]  rx_length,
    input  logic [15:0] rx_data,
    input  logic [15:0] rx_checksum,
    output entry_t      entry
);

    op_t         op;
    logic [15:0] crc_in;
    logic [15:0] crc_out;

    assign op      = op_t'(operation);
    assign crc_in  = (op == OP_SEND) ? {8'h00, switches & CMD_MASK} : rx_data;
    assign crc_out = crc_word(crc_in);

    always_comb
    begin
        entry       = '0;
        entry.op    = op;
        entry.crc   = crc_out;
        entry.stall = rx_data[RX_STALL_BIT];
        entry.full  = rx_data[RX_FULL_BIT];
        if (op == OP_SEND)
        begin
            entry.cmd = switches & CMD_MASK;
        end
        else
        begin
            entry.cmd = rx_data[7:0];
        end
        entry.rx_ok = (rx_length == RX_GOOD_LEN) && (crc_out == rx_checksum);
    end

endmodule

/* sv/clsu_queue.sv */
`timescale 1ns / 1ps
// clsu_queue: short register queue between the classifying front and the executing back
// holds classified entries; uses clsu_pkg

module clsu_queue
    import clsu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_entry,
    output logic   full,
    input  logic   rd_en,
    output logic   rd_valid,
    output entry_t rd_entry
);

    entry_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_next;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

/* sv/clsu_back.sv */
`timescale 1ns / 1ps
// clsu_back: executes queued entries against the link state and registers the result item
// holds the configuration registers and window, miss and light state; uses clsu_pkg

module clsu_back
    import clsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        q_valid,
    input  entry_t      q_entry,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_result
);

    logic [15:0] timeout_ticks_reg;
    logic [7:0]  missed_limit_reg;
    logic [7:0]  last_command_reg;
    logic        window_open_reg;
    logic [15:0] window_ticks_reg;
    logic [7:0]  misses_reg;
    logic        desync_reg;
    logic        stall_reg;
    logic        full_reg;
    logic        out_valid_reg;
    result_t     out_result_reg;

    logic [7:0]  last_command_next;
    logic        window_open_next;
    logic [15:0] window_ticks_next;
    logic [7:0]  misses_next;
    logic        desync_next;
    logic        stall_next;
    logic        full_next;
    logic        out_valid_next;
    result_t     result;

    logic [7:0]  misses_inc;
    logic        desync_on_miss;
    logic [15:0] ticks_inc;

    assign q_pop      = q_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    assign misses_inc     = (misses_reg == 8'hFF) ? misses_reg : misses_reg + 8'd1;
    assign desync_on_miss = desync_reg || (misses_inc >= missed_limit_reg);
    assign ticks_inc      = (window_ticks_reg == 16'hFFFF) ? window_ticks_reg
                                                           : window_ticks_reg + 16'd1;

    always_comb
    begin
        last_command_next = last_command_reg;
        window_open_next  = window_open_reg;
        window_ticks_next = window_ticks_reg;
        misses_next       = misses_reg;
        desync_next       = desync_reg;
        stall_next        = stall_reg;
        full_next         = full_reg;
        result            = '0;
        unique case (q_entry.op)
            OP_SEND:
            begin
                if (window_open_reg)
                begin
                    misses_next = misses_inc;
                    desync_next = desync_on_miss;
                end
                last_command_next  = q_entry.cmd;
                window_open_next   = 1'b1;
                window_ticks_next  = '0;
                result.tx_valid    = 1'b1;
                result.tx_data     = q_entry.cmd;
                result.tx_checksum = q_entry.crc;
            end
            OP_PACKET:
            begin
                if (window_open_reg && q_entry.rx_ok && (q_entry.cmd == last_command_reg))
                begin
                    result.ack_seen   = 1'b1;
                    window_open_next  = 1'b0;
                    window_ticks_next = '0;
                    misses_next       = '0;
                    desync_next       = 1'b0;
                    stall_next        = q_entry.stall;
                    full_next         = q_entry.full;
                end
            end
            OP_TICK:
            begin
                if (window_open_reg)
                begin
                    window_ticks_next = ticks_inc;
                    if (ticks_inc >= timeout_ticks_reg)
                    begin
                        window_open_next  = 1'b0;
                        window_ticks_next = '0;
                        misses_next       = misses_inc;
                        desync_next       = desync_on_miss;
                    end
                end
            end
            default:
            begin
            end
        endcase
        result.desync_light = desync_next;
        result.stall_light  = stall_next;
        result.full_light   = full_next;
        result.missed_count = misses_next;
        out_valid_next      = q_pop || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_RESET;
            missed_limit_reg  <= LIMIT_RESET;
            last_command_reg  <= '0;
            window_open_reg   <= 1'b0;
            window_ticks_reg  <= '0;
            misses_reg        <= '0;
            desync_reg        <= 1'b0;
            stall_reg         <= 1'b0;
            full_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                    REG_MISSED_LIMIT:  missed_limit_reg  <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (q_pop)
            begin
                last_command_reg <= last_command_next;
                window_open_reg  <= window_open_next;
                window_ticks_reg <= window_ticks_next;
                misses_reg       <= misses_next;
                desync_reg       <= desync_next;
                stall_reg        <= stall_next;
                full_reg         <= full_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_result_reg <= result;
        end
    end

endmodule

/* sv/clsu_checker.sv */
`timescale 1ns / 1ps
// clsu_checker: port-level assertions for the command link supervisor
// bound to command_echo_link_supervisor; uses clsu_pkg

module clsu_checker
    import clsu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[23:0] == 24'h0)
        else $error("frame fields not zero without a frame");

    a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[24] |-> !m_tuser[0] && m_tdata[35:28] == 8'h0 && !m_tdata[25])
        else $error("acknowledge did not clear misses and desync");

    a_desync_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[35:28] == 8'h0 |-> !m_tdata[25])
        else $error("desync light on with zero misses");

endmodule

bind command_echo_link_supervisor clsu_checker u_clsu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking testbench for command_echo_link_supervisor
// drives command, packet and tick items on the input stream and checks every result item
// against an in-bench prediction of the link state; depends on clsu_pkg and the rtl

module tb;
    import clsu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // switches, rx_length, rx_data, rx_checksum
    logic [1:0]  s_tuser = '0;  // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;       // tx_data, tx_checksum, ack_seen, desync_light,
                                // stall_light, full_light, missed_count, zero pad
    logic [0:0]  m_tuser;       // tx_valid

    // predicted link state and register copies
    logic [15:0] cfg_timeout = TIMEOUT_RESET;
    logic [7:0]  cfg_limit = LIMIT_RESET;
    logic [7:0]  cmd_latched = '0;
    logic        win_open = 1'b0;
    logic [15:0] win_ticks = '0;
    logic [7:0]  miss_cnt = '0;
    logic        desync = 1'b0;
    logic        stall = 1'b0;
    logic        full = 1'b0;

    result_t pending_replies[$];

    bit in_gaps_en = 1'b1;
    bit out_gaps_en = 1'b1;
    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int frames_sent = 0;
    int acks_seen = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    command_echo_link_supervisor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= (out_gaps_en && $urandom_range(99) < 28) ? 1'b0 : 1'b1;
    end

    // reflected crc-16, low byte first, i.e. word bits 0 to 15 in order
    function automatic logic [15:0] link_crc16(input logic [15:0] word);
        logic [15:0] crc;
        logic        fb;
        crc = CRC_INIT;
        for (int i = 0; i < 16; i++)
        begin
            fb  = crc[0] ^ word[i];
            crc = crc >> 1;
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic void note_miss();
        if (miss_cnt != 8'hFF)
        begin
            miss_cnt++;
        end
        if (miss_cnt >= cfg_limit)
        begin
            desync = 1'b1;
        end
    endfunction

    function automatic void advance_link(input op_t op, input logic [7:0] sw,
                                         input logic [7:0] len, input logic [15:0] word,
                                         input logic [15:0] chk);
        result_t r;
        r = '0;
        case (op)
            OP_SEND:
            begin
                if (win_open)
                begin
                    note_miss();
                end
                cmd_latched   = sw & CMD_MASK;
                win_open      = 1'b1;
                win_ticks     = '0;
                r.tx_valid    = 1'b1;
                r.tx_data     = cmd_latched;
                r.tx_checksum = link_crc16({8'h00, cmd_latched});
                frames_sent++;
            end
            OP_PACKET:
            begin
                if (win_open && len == RX_GOOD_LEN && link_crc16(word) == chk
                    && word[7:0] == cmd_latched)
                begin
                    r.ack_seen = 1'b1;
                    win_open   = 1'b0;
                    win_ticks  = '0;
                    miss_cnt   = '0;
                    desync     = 1'b0;
                    stall      = word[RX_STALL_BIT];
                    full       = word[RX_FULL_BIT];
                    acks_seen++;
                end
            end
            OP_TICK:
            begin
                if (win_open)
                begin
                    if (win_ticks != 16'hFFFF)
                    begin
                        win_ticks++;
                    end
                    if (win_ticks >= cfg_timeout)
                    begin
                        win_open  = 1'b0;
                        win_ticks = '0;
                        note_miss();
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.desync_light = desync;
        r.stall_light  = stall;
        r.full_light   = full;
        r.missed_count = miss_cnt;
        pending_replies.push_back(r);
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_replies.size() == 0)
            begin
                $error("result item with nothing expected");
                fail_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("tx_valid", 16'(want.tx_valid), 16'(m_tuser[0]));
                check_field("tx_data", 16'(want.tx_data), 16'(m_tdata[7:0]));
                check_field("tx_checksum", want.tx_checksum, m_tdata[23:8]);
                check_field("ack_seen", 16'(want.ack_seen), 16'(m_tdata[24]));
                check_field("desync_light", 16'(want.desync_light), 16'(m_tdata[25]));
                check_field("stall_light", 16'(want.stall_light), 16'(m_tdata[26]));
                check_field("full_light", 16'(want.full_light), 16'(m_tdata[27]));
                check_field("missed_count", 16'(want.missed_count), 16'(m_tdata[35:28]));
            end
        end
    end

    task automatic send_item(input op_t op, input logic [7:0] sw, input logic [7:0] len,
                             input logic [15:0] word, input logic [15:0] chk);
        @(negedge clk);
        while (in_gaps_en && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {chk, word, len, sw};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        advance_link(op, sw, len, word, chk);
    endtask

    task automatic send_cmd(input logic [7:0] sw);
        send_item(OP_SEND, sw, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // well-formed echo of the current command with the given feedback bits
    task automatic send_ack(input logic st, input logic fl, input logic [5:0] upper);
        logic [15:0] word;
        word = {upper, fl, st, cmd_latched};
        send_item(OP_PACKET, 8'($urandom), RX_GOOD_LEN, word, link_crc16(word));
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
        settle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_TIMEOUT_TICKS)
        begin
            cfg_timeout = val;
        end
        else
        begin
            cfg_limit = val[7:0];
        end
        reg_writes++;
    endtask

    task automatic test_directed_basics();
        logic [15:0] word;
        send_item(OP_NONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_tick();
        send_item(OP_PACKET, 8'h00, RX_GOOD_LEN, 16'h0000, link_crc16(16'h0000));
        send_cmd(8'h00);
        send_cmd(8'hFF);
        send_cmd(8'h80);
        send_cmd(8'h7F);
        word = {8'h03, cmd_latched};
        send_item(OP_PACKET, 8'h00, 8'd3, word, link_crc16(word));
        send_item(OP_PACKET, 8'h00, 8'hFF, word, link_crc16(word));
        send_item(OP_PACKET, 8'h00, RX_GOOD_LEN, word, link_crc16(word) ^ 16'h8000);
        word = {8'h03, cmd_latched ^ 8'h01};
        send_item(OP_PACKET, 8'h00, RX_GOOD_LEN, word, link_crc16(word));
        send_item(OP_NONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_ack(1'b1, 1'b1, 6'h3F);
        send_ack(1'b0, 1'b0, 6'h00);
        send_cmd(8'hA5);
        send_tick();
        send_tick();
        send_ack(1'b0, 1'b1, 6'h15);
        send_cmd(8'h5A);
        send_ack(1'b1, 1'b0, 6'h2A);
        send_tick();
    endtask

    task automatic test_window_expiry();
        write_reg(REG_TIMEOUT_TICKS, 16'd1);
        write_reg(REG_MISSED_LIMIT, 16'd1);
        send_cmd(8'h3C);
        send_tick();
        send_tick();
        send_cmd(8'hC3);
        send_ack(1'b1, 1'b0, 6'h00);
        write_reg(REG_TIMEOUT_TICKS, 16'd3);
        write_reg(REG_MISSED_LIMIT, 16'd2);
        for (int i = 0; i < 3; i++)
        begin
            send_cmd(8'($urandom));
            repeat (3) send_tick();
        end
        send_cmd(8'h11);
        send_ack(1'b0, 1'b1, 6'h01);
        write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
        send_cmd(8'h22);
        repeat (5) send_tick();
        send_ack(1'b1, 1'b1, 6'h20);
    endtask

    task automatic test_miss_saturation();
        in_gaps_en  = 1'b0;
        out_gaps_en = 1'b0;
        write_reg(REG_TIMEOUT_TICKS, 16'd1);
        write_reg(REG_MISSED_LIMIT, 16'd255);
        repeat (260) send_cmd(8'($urandom));
        send_tick();
        send_tick();
        send_cmd(8'h81);
        send_ack(1'b0, 1'b0, 6'h00);
        in_gaps_en  = 1'b1;
        out_gaps_en = 1'b1;
    endtask

    task automatic run_random_phase(input int n_items);
        int          first;
        int          pick;
        int          k;
        logic [15:0] word;
        op_t         op;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                send_cmd(8'($urandom));
                k = (cfg_timeout <= 16'd10) ? $urandom_range(0, cfg_timeout + 1)
                                            : $urandom_range(0, 4);
                repeat (k) send_tick();
                pick = $urandom_range(99);
                if (pick < 15)
                begin
                    send_item(OP_PACKET, 8'($urandom), 8'($urandom_range(5, 255)),
                              {8'($urandom), cmd_latched}, 16'($urandom));
                end
                else if (pick < 25)
                begin
                    word = {8'($urandom), cmd_latched};
                    send_item(OP_PACKET, 8'($urandom), RX_GOOD_LEN, word,
                              link_crc16(word) ^ 16'($urandom_range(1, 65535)));
                end
                else if (pick < 33)
                begin
                    word = {8'($urandom), cmd_latched ^ 8'($urandom_range(1, 255))};
                    send_item(OP_PACKET, 8'($urandom), RX_GOOD_LEN, word, link_crc16(word));
                end
                pick = $urandom_range(99);
                if (pick < 60)
                begin
                    send_ack(1'($urandom), 1'($urandom), 6'($urandom));
                    if ($urandom_range(9) == 0)
                    begin
                        send_ack(1'($urandom), 1'($urandom), 6'($urandom));
                    end
                end
            end
            else
            begin
                op = ($urandom_range(99) < 3) ? OP_NONE : op_t'($urandom_range(0, 2));
                send_item(op, 8'($urandom), 8'($urandom_range(0, 7)), 16'($urandom),
                          16'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        write_reg(REG_TIMEOUT_TICKS, 16'd2);
        write_reg(REG_MISSED_LIMIT, 16'd3);
        run_random_phase(80);
        for (int p = 0; p < 3; p++)
        begin
            write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(1, 8)));
            write_reg(REG_MISSED_LIMIT, 16'($urandom_range(1, 6)));
            run_random_phase(70);
        end
        write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(9, 65535)));
        write_reg(REG_MISSED_LIMIT, 16'($urandom_range(1, 255)));
        run_random_phase(60);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_basics();
        test_window_expiry();
        test_miss_saturation();
        test_random_traffic();
        settle();
        repeat (8) @(posedge clk);
        $display("ran %0d items over %0d register writes: %0d frames, %0d acknowledgements",
                 items_sent, reg_writes, frames_sent, acks_seen);
        $display("checked %0d result items, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0 && pending_replies.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/clsu_pkg.sv
sv/clsu_front.sv
sv/clsu_queue.sv
sv/clsu_back.sv
sv/command_echo_link_supervisor.sv
sv/clsu_checker.sv
tb/tb.sv
